/* sv/lth_pkg.sv */
// Shared constants and status codes for the loop trip-count histogram.
package lth_pkg;

    localparam int MAX_LOOPS        = 64;
    localparam int ENTRIES_PER_LOOP = 32;

    localparam int LOOP_W  = $clog2(MAX_LOOPS);
    localparam int SLOT_W  = $clog2(ENTRIES_PER_LOOP);
    localparam int HELD_W  = SLOT_W + 1;
    localparam int ADDR_W  = LOOP_W + SLOT_W;
    localparam int KEY_W   = 31;
    localparam int CFG_W   = 7;
    localparam int STAT_W  = 3;

    localparam logic [KEY_W-1:0]  WEIGHT_MAX = {KEY_W{1'b1}};
    localparam logic [HELD_W-1:0] HELD_FULL  = HELD_W'(ENTRIES_PER_LOOP);

    localparam logic [STAT_W-1:0] STAT_COUNTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NEW     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADLOOP = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_READOK  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd6;
    localparam logic [STAT_W-1:0] STAT_UNUSED  = 3'd7;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

/* sv/loop_trip_count_histogram.sv */
// Loop trip-count histogram: per-loop table of distinct trip counts and their weights.
// Each request looks up its fill count (S_FILL); zero, bad-loop and read-empty requests
// then go to output, a read hit reads its pair (S_RDW), and a record searches the held
// entries in order (S_SRCH), adding one on a miss if room is left (S_MISS). The search
// reads one key/weight pair per cycle. A new request is taken once the result is queued.
// Reset (synchronous, aresetn low) clears the sequencer, loop count and per-loop fill valids.
module loop_trip_count_histogram
    import lth_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [LOOP_W-1:0]   s_loop_number,
    input  logic [KEY_W-1:0]    s_trip_count,
    input  logic [SLOT_W-1:0]   s_entry_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [HELD_W-1:0]   m_entries_held,
    output logic [KEY_W-1:0]    m_entry_key,
    output logic [KEY_W-1:0]    m_entry_weight
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_RDW  = 3'd3;
    localparam logic [2:0] S_MISS = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    loops_in_use_reg;
    logic [MAX_LOOPS-1:0] fill_vld_reg;

    logic                op_reg;
    logic [LOOP_W-1:0]   loop_reg;
    logic [KEY_W-1:0]    trip_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                loop_ok_reg;

    logic [HELD_W-1:0]   held_reg, held_next;
    logic [HELD_W-1:0]   idx_reg, idx_next;

    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [HELD_W-1:0]   res_held_reg, res_held_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [KEY_W-1:0]    res_wt_reg, res_wt_next;

    logic                m_valid_reg;
    logic [STAT_W-1:0]   m_status_reg;
    logic [HELD_W-1:0]   m_held_reg;
    logic [KEY_W-1:0]    m_key_reg;
    logic [KEY_W-1:0]    m_wt_reg;

    logic                accept;
    logic                out_load;

    // entry RAM controls
    logic                key_we, wt_we, fill_we;
    logic [ADDR_W-1:0]   ent_waddr, ent_raddr;
    logic [KEY_W-1:0]    wt_wdata;
    logic [KEY_W-1:0]    key_rdata, wt_rdata;
    logic [HELD_W-1:0]   fill_wdata, fill_rdata;
    logic [HELD_W-1:0]   held_cur;
    logic [HELD_W-1:0]   idx_inc;
    logic [KEY_W-1:0]    wt_sat;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_entries_held = m_held_reg;
    assign m_entry_key    = m_key_reg;
    assign m_entry_weight = m_wt_reg;

    lth_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(KEY_W)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (ent_waddr),
        .wdata (trip_reg),
        .raddr (ent_raddr),
        .rdata (key_rdata)
    );

    lth_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(KEY_W)) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (ent_waddr),
        .wdata (wt_wdata),
        .raddr (ent_raddr),
        .rdata (wt_rdata)
    );

    // fill count per loop; read address is the incoming loop number
    lth_ram #(.ADDR_BITS(LOOP_W), .DATA_BITS(HELD_W)) u_fill_ram (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (loop_reg),
        .wdata (fill_wdata),
        .raddr (s_loop_number),
        .rdata (fill_rdata)
    );

    assign held_cur = fill_vld_reg[loop_reg] ? fill_rdata : '0;
    assign idx_inc  = idx_reg + 1'b1;
    assign wt_sat   = (wt_rdata == WEIGHT_MAX) ? wt_rdata : wt_rdata + 1'b1;

    always_comb begin
        state_next      = state_reg;
        held_next       = held_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_held_next   = res_held_reg;
        res_key_next    = res_key_reg;
        res_wt_next     = res_wt_reg;
        key_we          = 1'b0;
        wt_we           = 1'b0;
        fill_we         = 1'b0;
        ent_raddr       = {loop_reg, idx_reg[SLOT_W-1:0]};
        ent_waddr       = {loop_reg, idx_reg[SLOT_W-1:0]};
        wt_wdata        = wt_sat;
        fill_wdata      = held_reg + 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                held_next     = loop_ok_reg ? held_cur : '0;
                res_held_next = loop_ok_reg ? held_cur : '0;
                res_key_next  = '0;
                res_wt_next   = '0;
                idx_next      = '0;
                priority if (op_reg == OP_RECORD && trip_reg == '0) begin
                    res_status_next = STAT_ZERO;
                    state_next      = S_OUT;
                end else if (!loop_ok_reg) begin
                    res_status_next = STAT_BADLOOP;
                    state_next      = S_OUT;
                end else if (op_reg == OP_READ) begin
                    if ({1'b0, slot_reg} >= held_cur) begin
                        res_status_next = STAT_EMPTY;
                        state_next      = S_OUT;
                    end else begin
                        ent_raddr  = {loop_reg, slot_reg};
                        state_next = S_RDW;
                    end
                end else if (held_cur == '0) begin
                    state_next = S_MISS;
                end else begin
                    ent_raddr  = {loop_reg, {SLOT_W{1'b0}}};
                    state_next = S_SRCH;
                end
            end
            S_RDW: begin
                res_status_next = STAT_READOK;
                res_key_next    = key_rdata;
                res_wt_next     = wt_rdata;
                state_next      = S_OUT;
            end
            S_SRCH: begin
                // compare the pair read last cycle; prefetch the next one on a miss
                if (key_rdata == trip_reg) begin
                    wt_we           = 1'b1;
                    res_status_next = STAT_COUNTED;
                    res_key_next    = trip_reg;
                    res_wt_next     = wt_sat;
                    state_next      = S_OUT;
                end else begin
                    idx_next = idx_inc;
                    if (idx_inc == held_reg) begin
                        state_next = S_MISS;
                    end else begin
                        ent_raddr = {loop_reg, idx_inc[SLOT_W-1:0]};
                    end
                end
            end
            S_MISS: begin
                if (held_reg == HELD_FULL) begin
                    res_status_next = STAT_FULL;
                    res_key_next    = '0;
                    res_wt_next     = '0;
                end else begin
                    ent_waddr       = {loop_reg, held_reg[SLOT_W-1:0]};
                    key_we          = 1'b1;
                    wt_we           = 1'b1;
                    wt_wdata        = KEY_W'(1);
                    fill_we         = 1'b1;
                    res_status_next = STAT_NEW;
                    res_held_next   = held_reg + 1'b1;
                    res_key_next    = trip_reg;
                    res_wt_next     = KEY_W'(1);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            loops_in_use_reg <= '0;
            fill_vld_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                loops_in_use_reg <= cfg_wdata;
            end
            if (fill_we) begin
                fill_vld_reg[loop_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= s_op;
            loop_reg    <= s_loop_number;
            trip_reg    <= s_trip_count;
            slot_reg    <= s_entry_slot;
            loop_ok_reg <= ({1'b0, s_loop_number} < loops_in_use_reg);
        end
        held_reg       <= held_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_held_reg   <= res_held_next;
        res_key_reg    <= res_key_next;
        res_wt_reg     <= res_wt_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_held_reg   <= res_held_reg;
            m_key_reg    <= res_key_reg;
            m_wt_reg     <= res_wt_reg;
        end
    end

endmodule

/* sv/lth_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module lth_ram #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 31
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/lth_checker.sv */
// Port-level checks for the loop trip-count histogram, bound to the top level.
module lth_checker
    import lth_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [STAT_W-1:0] m_status,
    input logic [HELD_W-1:0] m_entries_held,
    input logic [KEY_W-1:0]  m_entry_key,
    input logic [KEY_W-1:0]  m_entry_weight
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_key)
            && $stable(m_entry_weight) && $stable(m_entries_held))
        else $error("stalled result changed");

    // one request in flight: not ready right after an accept
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != STAT_UNUSED)
        else $error("undefined status code");

    a_badloop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_BADLOOP |->
            m_entries_held == '0 && m_entry_key == '0 && m_entry_weight == '0)
        else $error("bad-loop result carries data");

    a_new_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_NEW |->
            m_entry_weight == KEY_W'(1) && m_entries_held != '0 && m_entry_key != '0)
        else $error("new entry result malformed");

endmodule

bind loop_trip_count_histogram lth_checker u_lth_checker (.*);
